// ===== sv/dcp_pkg.sv =====
`default_nettype none

package dcp_pkg;

  // Field widths
  localparam int AMT_W     = 64;
  localparam int REQ_W     = 2;
  localparam int AGENT_W   = 3;
  localparam int CNT_W     = 4;
  localparam int STAT_W    = 2;
  localparam int DIV_CNT_W = $clog2(AMT_W);

  // Request types
  localparam logic [REQ_W-1:0] REQ_REBAL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TAKE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_OFFLINE = 2'd2;

  // Online count after reset
  localparam logic [CNT_W-1:0] ONLINE_RESET = 4'd8;

  // Counter write data select
  localparam logic [2:0] WR_SHARE    = 3'd0;
  localparam logic [2:0] WR_ADD      = 3'd1;
  localparam logic [2:0] WR_SUB_AMT  = 3'd2;
  localparam logic [2:0] WR_ZERO     = 3'd3;
  localparam logic [2:0] WR_SUB_NEED = 3'd4;
  localparam logic [2:0] WR_GOT      = 3'd5;

  // Balance register update select
  localparam logic [2:0] BAL_NONE  = 3'd0;
  localparam logic [2:0] BAL_ZERO  = 3'd1;
  localparam logic [2:0] BAL_SHREM = 3'd2;
  localparam logic [2:0] BAL_WDATA = 3'd3;
  localparam logic [2:0] BAL_RD    = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [AGENT_W-1:0] agent_id;
    logic [AMT_W-1:0]   amount;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [AMT_W-1:0]  agent_balance;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;
    logic              div_start;
    logic              rd_en;
    logic              rd_me;
    logic              wr_en;
    logic              wr_me;
    logic [2:0]        wr_op;
    logic              idx_clr;
    logic              idx_inc;
    logic              walk_clr;
    logic              walk_add;
    logic [2:0]        bal_op;
    logic              stat_load;
    logic [STAT_W-1:0] stat_val;
    logic              out_load;
  } dcp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             offline;
    logic [REQ_W-1:0] req_type;
    logic             div_done;
    logic             idx_last;
    logic             me_enough;
    logic             walk_short;
  } dcp_stat_t;

endpackage

`default_nettype wire

// ===== sv/distributed_credit_pool_core.sv =====
// Path by request: an offline agent goes straight to the result; add, no-op and a take
// that its own counter covers read that counter once; a take that walks n agents reads them
// in order; a rebalance runs a bit-serial divider, then writes one counter per cycle.
// Throughput: one word at a time; the next word is taken the cycle after the result
// is registered, while that result may still wait at the output.
// Reset: synchronous rst_n; all counters read zero and online_count is 8 at once.
`default_nettype none

module distributed_credit_pool_core
  import dcp_pkg::*;
#(
  parameter int NUM_AGENTS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data
);

  dcp_cmd_t  cmd;
  dcp_stat_t stat;

  dcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcp_dpath #(
    .NUM_AGENTS (NUM_AGENTS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/dcp_ram.sv =====
`default_nettype none

module dcp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/dcp_div.sv =====
`default_nettype none

module dcp_div
  import dcp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [AMT_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [AMT_W-1:0] quot,
  output logic      [CNT_W-1:0] rem
);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(AMT_W - 1);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AMT_W-1:0]     quot_r, quot_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     den_r, den_nxt;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // One quotient bit per cycle, restoring
  assign trial = {rem_r, quot_r[AMT_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[AMT_W-2:0], fits};
      rem_nxt  = fits ? CNT_W'(trial - {1'b0, den_r}) : trial[CNT_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign done = busy_r && (cnt_r == DIV_LAST);
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== sv/dcp_ctrl.sv =====
`default_nettype none

module dcp_ctrl
  import dcp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire dcp_stat_t stat,
  output dcp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RBW   = 4'd3;
  localparam logic [3:0] S_RDME  = 4'd4;
  localparam logic [3:0] S_TKME  = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_FAIL  = 4'd7;
  localparam logic [3:0] S_RDFIN = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequence one request through the datapath
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.idx_clr = 1'b1;
        if (stat.offline) begin
          cmd.bal_op    = BAL_ZERO;
          cmd.stat_load = 1'b1;
          cmd.stat_val  = ST_OFFLINE;
          state_nxt     = S_DONE;
        end else begin
          cmd.stat_load = 1'b1;
          cmd.stat_val  = ST_OK;
          unique case (stat.req_type)
            REQ_REBAL: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            REQ_TAKE: begin
              cmd.rd_en = 1'b1;
              cmd.rd_me = 1'b1;
              state_nxt = S_TKME;
            end
            REQ_ADD, REQ_NOP: begin
              cmd.rd_en = 1'b1;
              cmd.rd_me = 1'b1;
              state_nxt = S_RDME;
            end
          endcase
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_RBW;
        end
      end
      S_RBW: begin
        // write the share to each online counter, requester gets the remainder too
        cmd.wr_en = 1'b1;
        cmd.wr_op = WR_SHARE;
        if (stat.idx_last) begin
          cmd.bal_op = BAL_SHREM;
          state_nxt  = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RDME: begin
        if (stat.req_type == REQ_ADD) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_me  = 1'b1;
          cmd.wr_op  = WR_ADD;
          cmd.bal_op = BAL_WDATA;
        end else begin
          cmd.bal_op = BAL_RD;
        end
        state_nxt = S_DONE;
      end
      S_TKME: begin
        if (stat.me_enough) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_me  = 1'b1;
          cmd.wr_op  = WR_SUB_AMT;
          cmd.bal_op = BAL_WDATA;
          state_nxt  = S_DONE;
        end else begin
          cmd.walk_clr = 1'b1;
          cmd.rd_en    = 1'b1;
          state_nxt    = S_WALK;
        end
      end
      S_WALK: begin
        cmd.wr_en = 1'b1;
        if (stat.walk_short) begin
          // drain this counter and move on
          cmd.wr_op    = WR_ZERO;
          cmd.walk_add = 1'b1;
          if (stat.idx_last) begin
            state_nxt = S_FAIL;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_en   = 1'b1;
          end
        end else begin
          cmd.wr_op = WR_SUB_NEED;
          state_nxt = S_RDFIN;
        end
      end
      S_FAIL: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_me     = 1'b1;
        cmd.wr_op     = WR_GOT;
        cmd.bal_op    = BAL_WDATA;
        cmd.stat_load = 1'b1;
        cmd.stat_val  = ST_NOSPACE;
        state_nxt     = S_DONE;
      end
      S_RDFIN: begin
        cmd.rd_en = 1'b1;
        cmd.rd_me = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.bal_op = BAL_RD;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/dcp_dpath.sv =====
`default_nettype none

module dcp_dpath
  import dcp_pkg::*;
#(
  parameter int NUM_AGENTS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire in_word_t         in_data,
  input  wire dcp_cmd_t         cmd,
  output dcp_stat_t             stat,
  output out_word_t             out_data
);

  localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;

  logic [CNT_W-1:0]      online_r;
  logic [CNT_W-1:0]      n_eff;
  logic [REQ_W-1:0]      req_type_r;
  logic [AGENT_W-1:0]    agent_r;
  logic [AMT_W-1:0]      amount_r;
  logic [CNT_W-1:0]      n_r;
  logic [CNT_W-1:0]      idx_r, idx_nxt, rd_idx;
  logic [AMT_W-1:0]      got_r, need_r;
  logic [AMT_W-1:0]      bal_r, bal_nxt;
  logic [STAT_W-1:0]     stat_r;
  out_word_t             out_r;
  logic [NUM_AGENTS-1:0] valid_r;
  logic                  vld_q;
  logic [AW-1:0]         me_addr, waddr, raddr;
  logic [AMT_W-1:0]      ram_rdata, rd_val, wdata, share_rem;
  logic                  div_done;
  logic [AMT_W-1:0]      quot;
  logic [CNT_W-1:0]      rem;

  // Clamp the online count to one .. NUM_AGENTS
  always_comb begin
    if (online_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(online_r) > NUM_AGENTS) begin
      n_eff = CNT_W'(NUM_AGENTS);
    end else begin
      n_eff = online_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= ONLINE_RESET;
    end else if (cfg_wr_en) begin
      online_r <= cfg_wr_data;
    end
  end

  // Latch the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= in_data.req_type;
      agent_r    <= in_data.agent_id;
      amount_r   <= in_data.amount;
      n_r        <= n_eff;
    end
  end

  // Walk index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end
  assign rd_idx = cmd.idx_inc ? idx_r + 1'b1 : idx_r;

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // Gathered credit and what is still missing
  always_ff @(posedge clk) begin
    if (cmd.walk_clr) begin
      got_r  <= '0;
      need_r <= amount_r;
    end else if (cmd.walk_add) begin
      got_r  <= got_r + rd_val;
      need_r <= need_r - rd_val;
    end
  end

  // Counter store: never-written entries read as zero
  assign me_addr = AW'(agent_r);
  assign waddr   = cmd.wr_me ? me_addr : AW'(idx_r);
  assign raddr   = cmd.rd_me ? me_addr : AW'(rd_idx);

  dcp_ram #(
    .WIDTH (AMT_W),
    .DEPTH (NUM_AGENTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      vld_q <= valid_r[raddr];
    end
  end

  assign rd_val = vld_q ? ram_rdata : '0;

  // Share per agent
  dcp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (amount_r),
    .divisor  (n_r),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign share_rem = quot + AMT_W'(rem);

  // Counter write data
  always_comb begin
    unique case (cmd.wr_op)
      WR_SHARE:    wdata = (AW'(idx_r) == me_addr) ? share_rem : quot;
      WR_ADD:      wdata = rd_val + amount_r;
      WR_SUB_AMT:  wdata = rd_val - amount_r;
      WR_ZERO:     wdata = '0;
      WR_SUB_NEED: wdata = rd_val - need_r;
      WR_GOT:      wdata = got_r;
      default:     wdata = '0;
    endcase
  end

  // Requester balance and status
  always_comb begin
    unique case (cmd.bal_op)
      BAL_ZERO:  bal_nxt = '0;
      BAL_SHREM: bal_nxt = share_rem;
      BAL_WDATA: bal_nxt = wdata;
      BAL_RD:    bal_nxt = rd_val;
      default:   bal_nxt = bal_r;
    endcase
  end

  always_ff @(posedge clk) begin
    bal_r <= bal_nxt;
    if (cmd.stat_load) begin
      stat_r <= cmd.stat_val;
    end
    if (cmd.out_load) begin
      out_r.status        <= stat_r;
      out_r.agent_balance <= bal_r;
    end
  end

  assign out_data = out_r;

  // Status back to the controller
  assign stat.offline    = {1'b0, agent_r} >= n_r;
  assign stat.req_type   = req_type_r;
  assign stat.div_done   = div_done;
  assign stat.idx_last   = (idx_r == n_r - CNT_W'(1));
  assign stat.me_enough  = rd_val >= amount_r;
  assign stat.walk_short = rd_val < need_r;

endmodule

`default_nettype wire

// ===== sv/dcp_checker.sv =====
`default_nettype none

module dcp_checker
  import dcp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_data
);

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // One word at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a word is in progress");

  // A new result only comes out of a busy block
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a word in progress");

  // A refused agent reports a zero balance
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OFFLINE) |-> (out_data.agent_balance == '0))
    else $error("offline result with nonzero balance");

endmodule

bind distributed_credit_pool_core dcp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dcp_pkg::*;

  localparam int AGENTS = 8;
  localparam logic [AMT_W-1:0] AMT_MAX = '1;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_word_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;

  // Shadow copy of the pool: counters and the online count register
  logic [AMT_W-1:0] pool_credit [AGENTS];
  logic [CNT_W-1:0] pool_online = ONLINE_RESET;

  out_word_t balance_q [$];
  out_word_t want_word;
  int        fail_count = 0;
  bit        steady = 1'b0;

  distributed_credit_pool_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp the register to the agents that actually exist
  function automatic int unsigned online_n();
    if (pool_online == 0) return 1;
    if (pool_online > AGENTS) return AGENTS;
    return pool_online;
  endfunction

  // Apply one request word to the shadow pool and return the result word
  function automatic out_word_t pool_predict(in_word_t w);
    out_word_t        r;
    int unsigned      n;
    int               i;
    logic [AMT_W-1:0] share;
    logic [AMT_W-1:0] got;
    logic [AMT_W-1:0] need;
    n = online_n();
    r.status = ST_OK;
    r.agent_balance = '0;
    if (w.agent_id >= n) begin
      r.status = ST_OFFLINE;
      return r;
    end
    case (w.req_type)
      REQ_REBAL: begin
        share = w.amount / n;
        for (i = 0; i < n; i++) pool_credit[i] = share;
        pool_credit[w.agent_id] += w.amount - share * n;
      end
      REQ_ADD: pool_credit[w.agent_id] += w.amount;
      REQ_TAKE: begin
        if (pool_credit[w.agent_id] >= w.amount) begin
          pool_credit[w.agent_id] -= w.amount;
        end else begin
          // walk online agents in order, draining until the amount is covered
          got = '0;
          for (i = 0; i < n && got != w.amount; i++) begin
            need = w.amount - got;
            if (pool_credit[i] < need) begin
              got += pool_credit[i];
              pool_credit[i] = '0;
            end else begin
              pool_credit[i] -= need;
              got = w.amount;
            end
          end
          if (got != w.amount) begin
            pool_credit[w.agent_id] += got;
            r.status = ST_NOSPACE;
          end
        end
      end
      default: ;
    endcase
    r.agent_balance = pool_credit[w.agent_id];
    return r;
  endfunction

  // Send one request word; record its expected result once accepted
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [AGENT_W-1:0] who,
                           input logic [AMT_W-1:0] amt);
    in_word_t w;
    int       gap;
    w.req_type = kind;
    w.agent_id = who;
    w.amount   = amt;
    gap = 0;
    if (!steady) begin
      while (gap < 20 && $urandom_range(99) < 32) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    balance_q.push_back(pool_predict(w));
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic wait_pool_idle();
    in_valid <= 1'b0;
    while (balance_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_online(input logic [CNT_W-1:0] value);
    wait_pool_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    pool_online = value;
  endtask

  // Amounts that land near the interesting take and wrap boundaries
  function automatic logic [AMT_W-1:0] pick_amount(logic [AGENT_W-1:0] who);
    logic [AMT_W:0] total;
    int             i;
    total = '0;
    for (i = 0; i < online_n(); i++) total += pool_credit[i];
    case ($urandom_range(7))
      0: return {$urandom, $urandom};
      1: return $urandom_range(15);
      2: return {$urandom, $urandom} >> $urandom_range(63);
      3: return AMT_MAX - $urandom_range(3);
      4: return pool_credit[who] + $urandom_range(2) - 1;
      5: begin
        if (total > {1'b0, AMT_MAX}) return AMT_MAX;
        return total[AMT_W-1:0] + $urandom_range(2) - 1;
      end
      6: return pool_credit[$urandom_range(AGENTS - 1)] + $urandom_range(1);
      default: return {32'h0, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_word(REQ_NOP,   3'd0, 64'd0);
    send_word(REQ_ADD,   3'd0, AMT_MAX);
    send_word(REQ_ADD,   3'd0, 64'd1);
    send_word(REQ_REBAL, 3'd5, AMT_MAX);
    send_word(REQ_TAKE,  3'd1, AMT_MAX);
    send_word(REQ_REBAL, 3'd2, 64'd0);
    send_word(REQ_REBAL, 3'd7, 64'd23);
    send_word(REQ_TAKE,  3'd7, 64'd9);
    send_word(REQ_TAKE,  3'd3, 64'd5);
    send_word(REQ_TAKE,  3'd4, 64'd1000);
    send_word(REQ_TAKE,  3'd0, 64'd0);
    send_word(REQ_ADD,   3'd6, AMT_MAX);
    send_word(REQ_NOP,   3'd7, AMT_MAX);
  endtask

  // Agents beyond the online count are refused and keep their counters
  task automatic test_offline();
    write_online(4'd3);
    send_word(REQ_REBAL, 3'd1, 64'd100);
    send_word(REQ_ADD,   3'd5, 64'd7);
    send_word(REQ_TAKE,  3'd7, 64'd1);
    send_word(REQ_NOP,   3'd3, 64'd0);
    send_word(REQ_TAKE,  3'd2, 64'd200);
    write_online(4'd8);
    send_word(REQ_NOP,   3'd6, 64'd0);
  endtask

  // Count zero acts as one agent, counts past the agent total saturate
  task automatic test_count_limits();
    write_online(4'd0);
    send_word(REQ_REBAL, 3'd0, AMT_MAX);
    send_word(REQ_ADD,   3'd1, 64'd1);
    write_online(4'd15);
    send_word(REQ_NOP,   3'd7, 64'd0);
    // walk over counters whose sum exceeds the 64-bit range
    write_online(4'd2);
    send_word(REQ_REBAL, 3'd1, AMT_MAX);
    send_word(REQ_ADD,   3'd0, 64'h8000_0000_0000_0000);
    send_word(REQ_TAKE,  3'd1, AMT_MAX);
  endtask

  task automatic test_random();
    logic [CNT_W-1:0]   counts [8] = '{4'd8, 4'd1, 4'd15, 4'd2, 4'd0, 4'd5, 4'd8, 4'd3};
    logic [REQ_W-1:0]   kind;
    logic [AGENT_W-1:0] who;
    int                 p;
    int                 k;
    int                 pick;
    for (p = 0; p < 8; p++) begin
      write_online(counts[p]);
      steady = (p == 6);
      for (k = 0; k < 140; k++) begin
        pick = $urandom_range(99);
        if (pick < 18) kind = REQ_REBAL;
        else if (pick < 48) kind = REQ_ADD;
        else if (pick < 90) kind = REQ_TAKE;
        else kind = REQ_NOP;
        // mostly online agents, with some refused requests mixed in
        if ($urandom_range(99) < 85) who = $urandom_range(online_n() - 1);
        else who = $urandom_range(AGENTS - 1);
        send_word(kind, who, pick_amount(who));
      end
      steady = 1'b0;
    end
  endtask

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (balance_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: status %0d balance %h",
                   out_data.status, out_data.agent_balance);
      end else begin
        want_word = balance_q.pop_front();
        if (out_data.status !== want_word.status ||
            out_data.agent_balance !== want_word.agent_balance) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected status %0d balance %h, got status %0d balance %h",
                     want_word.status, want_word.agent_balance,
                     out_data.status, out_data.agent_balance);
        end
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 32);
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < AGENTS; i++) pool_credit[i] = '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_offline();
    test_count_limits();
    test_random();
    wait_pool_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && balance_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
